FILE: hw/rtl/aqi_pkg.sv
// Shared constants, breakpoint tables and types for the air quality index block.
package aqi_pkg;

  // Concentration format and field widths.
  localparam int unsigned CONC_FRAC_BITS = 4;
  localparam int unsigned CONC_IN_W      = 16;
  localparam int unsigned CONC_W         = CONC_IN_W - 1;
  localparam int unsigned IDX_W          = 9;
  localparam int unsigned CAT_W          = 3;
  localparam int unsigned COLOR_W        = 8;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_USE_PM25 = 1'b0;
  localparam logic        REG_USE_PM10 = 1'b1;

  // Pipeline: two stages in each lane, two in the merge stage.
  localparam int unsigned PIPE_DEPTH = 4;

  // Breakpoint tables.
  localparam int unsigned NUM_SEG = 5;
  localparam int unsigned SEG_W   = $clog2(NUM_SEG);
  localparam int unsigned ABOVE_TOP_INDEX = 500;
  localparam int unsigned FULL_SCALE      = 255;

  localparam int unsigned PM25_BP [NUM_SEG+1] = '{0, 15, 30, 55, 110, 250};
  localparam int unsigned PM10_BP [NUM_SEG+1] = '{0, 45, 90, 180, 270, 400};
  localparam int unsigned IDX_BP  [NUM_SEG+1] = '{0, 50, 100, 150, 200, 300};

  localparam int unsigned IDX_RISE [NUM_SEG] = '{
    IDX_BP[1] - IDX_BP[0], IDX_BP[2] - IDX_BP[1], IDX_BP[3] - IDX_BP[2],
    IDX_BP[4] - IDX_BP[3], IDX_BP[5] - IDX_BP[4]
  };

  localparam int unsigned PM25_SPAN [NUM_SEG] = '{
    (PM25_BP[1] - PM25_BP[0]) << CONC_FRAC_BITS, (PM25_BP[2] - PM25_BP[1]) << CONC_FRAC_BITS,
    (PM25_BP[3] - PM25_BP[2]) << CONC_FRAC_BITS, (PM25_BP[4] - PM25_BP[3]) << CONC_FRAC_BITS,
    (PM25_BP[5] - PM25_BP[4]) << CONC_FRAC_BITS
  };
  localparam int unsigned PM10_SPAN [NUM_SEG] = '{
    (PM10_BP[1] - PM10_BP[0]) << CONC_FRAC_BITS, (PM10_BP[2] - PM10_BP[1]) << CONC_FRAC_BITS,
    (PM10_BP[3] - PM10_BP[2]) << CONC_FRAC_BITS, (PM10_BP[4] - PM10_BP[3]) << CONC_FRAC_BITS,
    (PM10_BP[5] - PM10_BP[4]) << CONC_FRAC_BITS
  };

  // Interpolation: rise * delta fits NUM_W bits, and the quotient by the span
  // is taken as (num * ceil(2^RECIP_SHIFT / span)) >> RECIP_SHIFT, which is
  // exact because num * error stays below 2^RECIP_SHIFT for every segment.
  localparam int unsigned RISE_W      = 7;
  localparam int unsigned NUM_W       = 18;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;
  localparam int unsigned QUO_W       = 7;
  localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;

  localparam longint unsigned PM25_RECIP [NUM_SEG] = '{
    (RECIP_ONE + PM25_SPAN[0] - 1) / PM25_SPAN[0], (RECIP_ONE + PM25_SPAN[1] - 1) / PM25_SPAN[1],
    (RECIP_ONE + PM25_SPAN[2] - 1) / PM25_SPAN[2], (RECIP_ONE + PM25_SPAN[3] - 1) / PM25_SPAN[3],
    (RECIP_ONE + PM25_SPAN[4] - 1) / PM25_SPAN[4]
  };
  localparam longint unsigned PM10_RECIP [NUM_SEG] = '{
    (RECIP_ONE + PM10_SPAN[0] - 1) / PM10_SPAN[0], (RECIP_ONE + PM10_SPAN[1] - 1) / PM10_SPAN[1],
    (RECIP_ONE + PM10_SPAN[2] - 1) / PM10_SPAN[2], (RECIP_ONE + PM10_SPAN[3] - 1) / PM10_SPAN[3],
    (RECIP_ONE + PM10_SPAN[4] - 1) / PM10_SPAN[4]
  };

  // Colour ramp: 255 * x / span through a reciprocal with a 24-bit shift.
  localparam int unsigned COL_SHIFT     = 24;
  localparam int unsigned COL_RECIP_W   = 19;
  localparam int unsigned COL_NUM_W     = 16;
  localparam int unsigned COL_PROD_W    = COL_NUM_W + COL_RECIP_W;
  localparam int unsigned COL_MID_SPAN  = IDX_BP[2] - IDX_BP[1];
  localparam int unsigned COL_HIGH_SPAN = IDX_BP[5] - IDX_BP[2];
  localparam logic [COL_RECIP_W-1:0] COL_MID_RECIP =
    COL_RECIP_W'(((64'd1 << COL_SHIFT) + COL_MID_SPAN - 1) / COL_MID_SPAN);
  localparam logic [COL_RECIP_W-1:0] COL_HIGH_RECIP =
    COL_RECIP_W'(((64'd1 << COL_SHIFT) + COL_HIGH_SPAN - 1) / COL_HIGH_SPAN);

  // Category codes.
  localparam logic [CAT_W-1:0] CAT_GOOD           = 3'd0;
  localparam logic [CAT_W-1:0] CAT_MODERATE       = 3'd1;
  localparam logic [CAT_W-1:0] CAT_SENSITIVE      = 3'd2;
  localparam logic [CAT_W-1:0] CAT_UNHEALTHY      = 3'd3;
  localparam logic [CAT_W-1:0] CAT_VERY_UNHEALTHY = 3'd4;
  localparam logic [CAT_W-1:0] CAT_HAZARDOUS      = 3'd5;

  typedef enum logic [1:0] {
    COL_LOW,
    COL_MID,
    COL_HIGH,
    COL_TOP
  } col_range_e;

  typedef struct packed {
    logic [NUM_SEG-1:0][CONC_W-1:0]  lo;
    logic [NUM_SEG-1:0][CONC_W-1:0]  hi;
    logic [NUM_SEG-1:0][RECIP_W-1:0] recip;
  } lane_tab_t;

  typedef struct packed {
    logic lane_s1;
    logic lane_s2;
    logic merge_s1;
    logic merge_s2;
  } pipe_en_t;

  typedef struct packed {
    logic [IDX_W-1:0]   pm25_index;
    logic [IDX_W-1:0]   pm10_index;
    logic [IDX_W-1:0]   final_index;
    logic [CAT_W-1:0]   category;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } result_t;

  // Breakpoints and reciprocals of one pollutant, in concentration units.
  function automatic lane_tab_t lane_tab(input logic pm10);
    lane_tab_t t;
    for (int i = 0; i < NUM_SEG; i++) begin
      if (pm10) begin
        t.lo[i]    = CONC_W'(PM10_BP[i] << CONC_FRAC_BITS);
        t.hi[i]    = CONC_W'(PM10_BP[i+1] << CONC_FRAC_BITS);
        t.recip[i] = RECIP_W'(PM10_RECIP[i]);
      end else begin
        t.lo[i]    = CONC_W'(PM25_BP[i] << CONC_FRAC_BITS);
        t.hi[i]    = CONC_W'(PM25_BP[i+1] << CONC_FRAC_BITS);
        t.recip[i] = RECIP_W'(PM25_RECIP[i]);
      end
    end
    return t;
  endfunction

endpackage

FILE: hw/rtl/aqi_if.sv
// Valid/ready channel interfaces for concentration items and index results.
interface aqi_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [aqi_pkg::CONC_IN_W-1:0]   pm25_conc;
  logic signed [aqi_pkg::CONC_IN_W-1:0]   pm10_conc;

  modport source (output valid, output pm25_conc, output pm10_conc, input ready);
  modport sink (input valid, input pm25_conc, input pm10_conc, output ready);
endinterface

interface aqi_out_if;
  logic                          valid;
  logic                          ready;
  logic [aqi_pkg::IDX_W-1:0]     pm25_index;
  logic [aqi_pkg::IDX_W-1:0]     pm10_index;
  logic [aqi_pkg::IDX_W-1:0]     final_index;
  logic [aqi_pkg::CAT_W-1:0]     category;
  logic [aqi_pkg::COLOR_W-1:0]   red;
  logic [aqi_pkg::COLOR_W-1:0]   green;
  logic [aqi_pkg::COLOR_W-1:0]   blue;

  modport source (output valid, output pm25_index, output pm10_index, output final_index,
                  output category, output red, output green, output blue, input ready);
  modport sink (input valid, input pm25_index, input pm10_index, input final_index,
                input category, input red, input green, input blue, output ready);
endinterface

FILE: hw/rtl/air_quality_index_calc.sv
// Air quality index calculator: two sub-index lanes, merge stage, APB registers.
// Pipeline: an accepted item passes two register stages in each lane and then
// two in the merge stage, whose last register drives the output channel.
// Throughput: one item per cycle while the output is not stalled; every stage holds
// one item and moves on whenever the stage after it is free or moving, so a stall only backs up.
// Reset: rst_ni clears all pipeline valid bits at once and sets both enables.
module air_quality_index_calc (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  aqi_in_if.sink                             in_if,
  aqi_out_if.source                          out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [aqi_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [aqi_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [aqi_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  // Configuration registers. Each register sits at a 4-byte address; only
  // bit 2 of the address picks the register and only bit 0 of the data is kept.
  logic use_pm25_q, use_pm25_d;
  logic use_pm10_q, use_pm10_d;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    use_pm25_d = use_pm25_q;
    use_pm10_d = use_pm10_q;
    if (cfg_wr && (paddr[2] == aqi_pkg::REG_USE_PM25)) begin
      use_pm25_d = pwdata[0];
    end
    if (cfg_wr && (paddr[2] == aqi_pkg::REG_USE_PM10)) begin
      use_pm10_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_pm25_q <= 1'b1;
      use_pm10_q <= 1'b1;
    end else begin
      use_pm25_q <= use_pm25_d;
      use_pm10_q <= use_pm10_d;
    end
  end

  assign prdata = aqi_pkg::CFG_DATA_W'((paddr[2] == aqi_pkg::REG_USE_PM10) ? use_pm10_q
                                                                          : use_pm25_q);

  // Pipeline control. Stage k takes a new item whenever it is empty or the
  // stage after it is taking its item, so the last stage acts as the output
  // register and a full, stalled pipeline still holds every item in place.
  logic [aqi_pkg::PIPE_DEPTH-1:0] valid_q, valid_d, shift_in;
  logic [aqi_pkg::PIPE_DEPTH:0]   rdy;
  aqi_pkg::pipe_en_t              en;

  always_comb begin
    rdy[aqi_pkg::PIPE_DEPTH] = out_if.ready;
    for (int k = aqi_pkg::PIPE_DEPTH - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    shift_in = {valid_q[aqi_pkg::PIPE_DEPTH-2:0], in_if.valid};
    for (int k = 0; k < aqi_pkg::PIPE_DEPTH; k++) begin
      valid_d[k] = rdy[k] ? shift_in[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign en.lane_s1  = rdy[0];
  assign en.lane_s2  = rdy[1];
  assign en.merge_s1 = rdy[2];
  assign en.merge_s2 = rdy[3];

  assign in_if.ready  = rdy[0];
  assign out_if.valid = valid_q[aqi_pkg::PIPE_DEPTH-1];

  // The two lanes run the same interpolation core on their own breakpoints.
  logic [aqi_pkg::IDX_W-1:0] pm25_index;
  logic [aqi_pkg::IDX_W-1:0] pm10_index;
  aqi_pkg::result_t          result;

  aqi_lane u_lane_pm25 (
    .clk_i   (clk_i),
    .en_i    (en),
    .tab_i   (aqi_pkg::lane_tab(1'b0)),
    .conc_i  (in_if.pm25_conc),
    .index_o (pm25_index)
  );

  aqi_lane u_lane_pm10 (
    .clk_i   (clk_i),
    .en_i    (en),
    .tab_i   (aqi_pkg::lane_tab(1'b1)),
    .conc_i  (in_if.pm10_conc),
    .index_o (pm10_index)
  );

  // The merge stage takes the larger enabled index and derives the category
  // and the colour; its second register drives the output channel.
  aqi_merge u_merge (
    .clk_i        (clk_i),
    .en_i         (en),
    .use_pm25_i   (use_pm25_q),
    .use_pm10_i   (use_pm10_q),
    .pm25_index_i (pm25_index),
    .pm10_index_i (pm10_index),
    .result_o     (result)
  );

  assign out_if.pm25_index  = result.pm25_index;
  assign out_if.pm10_index  = result.pm10_index;
  assign out_if.final_index = result.final_index;
  assign out_if.category    = result.category;
  assign out_if.red         = result.red;
  assign out_if.green       = result.green;
  assign out_if.blue        = result.blue;

`ifndef NO_ASSERTIONS
  // Back-pressure only reaches the input once every stage holds an item.
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (&valid_q))
    else $error("input blocked while a pipeline stage is empty");

  // The final index is always one of the sub-indices or zero.
  a_final_is_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.final_index == '0) ||
                     (out_if.final_index == out_if.pm25_index) ||
                     (out_if.final_index == out_if.pm10_index))
    else $error("final index matches no sub-index");

  // The PM2.5 lane gives an interpolated index or the above-range value only.
  a_pm25_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.pm25_index <= aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[5])) ||
                     (out_if.pm25_index == aqi_pkg::IDX_W'(aqi_pkg::ABOVE_TOP_INDEX)))
    else $error("PM2.5 sub-index out of range");

  // Above the top of the scale the item is hazardous and shown full red.
  a_top_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && (out_if.final_index > aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[5])) |->
      (out_if.category == aqi_pkg::CAT_HAZARDOUS) &&
      (out_if.red == aqi_pkg::COLOR_W'(aqi_pkg::FULL_SCALE)))
    else $error("index above scale without hazardous category and red");
`endif

endmodule

FILE: hw/rtl/aqi_lane.sv
// One sub-index lane: segment search, interpolation product, reciprocal divide.
module aqi_lane (
  input  logic                            clk_i,
  input  aqi_pkg::pipe_en_t               en_i,
  input  aqi_pkg::lane_tab_t              tab_i,
  input  logic [aqi_pkg::CONC_IN_W-1:0]   conc_i,
  output logic [aqi_pkg::IDX_W-1:0]       index_o
);

  logic [aqi_pkg::CONC_W-1:0] conc;
  logic [aqi_pkg::CONC_W-1:0] delta;
  logic [aqi_pkg::RISE_W-1:0] rise;
  logic [aqi_pkg::SEG_W-1:0]  seg_d, seg_q;
  logic                       above_d, above_q;
  logic [aqi_pkg::NUM_W-1:0]  num_d, num_q;
  logic [aqi_pkg::PROD_W-1:0] prod;
  logic [aqi_pkg::QUO_W-1:0]  quo;
  logic [aqi_pkg::IDX_W-1:0]  index_d, index_q;

  // Stage 1: clamp negatives, find the first segment that holds the value, form the product.
  always_comb begin
    conc    = conc_i[aqi_pkg::CONC_IN_W-1] ? '0 : conc_i[aqi_pkg::CONC_W-1:0];
    seg_d   = '0;
    above_d = 1'b1;
    for (int i = aqi_pkg::NUM_SEG - 1; i >= 0; i--) begin
      if (conc <= tab_i.hi[i]) begin
        seg_d   = aqi_pkg::SEG_W'(i);
        above_d = 1'b0;
      end
    end
    delta = conc - tab_i.lo[seg_d];
    rise  = aqi_pkg::RISE_W'(aqi_pkg::IDX_RISE[seg_d]);
    num_d = aqi_pkg::NUM_W'(rise) * aqi_pkg::NUM_W'(delta);
  end

  // Stage 2: divide by the segment span and add the segment base, or give the above-range index.
  always_comb begin
    prod    = aqi_pkg::PROD_W'(num_q) * aqi_pkg::PROD_W'(tab_i.recip[seg_q]);
    quo     = prod[aqi_pkg::RECIP_SHIFT +: aqi_pkg::QUO_W];
    index_d = above_q ? aqi_pkg::IDX_W'(aqi_pkg::ABOVE_TOP_INDEX)
                      : aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[seg_q]) + aqi_pkg::IDX_W'(quo);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.lane_s1) begin
      num_q   <= num_d;
      seg_q   <= seg_d;
      above_q <= above_d;
    end
    if (en_i.lane_s2) begin
      index_q <= index_d;
    end
  end

  assign index_o = index_q;

endmodule

FILE: hw/rtl/aqi_merge.sv
// Merge stage: final index, category and colour ramp from the two lanes.
module aqi_merge (
  input  logic                        clk_i,
  input  aqi_pkg::pipe_en_t           en_i,
  input  logic                        use_pm25_i,
  input  logic                        use_pm10_i,
  input  logic [aqi_pkg::IDX_W-1:0]   pm25_index_i,
  input  logic [aqi_pkg::IDX_W-1:0]   pm10_index_i,
  output aqi_pkg::result_t            result_o
);

  logic [aqi_pkg::IDX_W-1:0]       final_d, final_q;
  logic [aqi_pkg::CAT_W-1:0]       cat_d, cat_q;
  aqi_pkg::col_range_e             rng_d, rng_q;
  logic [aqi_pkg::IDX_W-1:0]       xa, xb;
  logic [aqi_pkg::COL_NUM_W-1:0]   na_d, na_q, nb_d, nb_q;
  logic [aqi_pkg::IDX_W-1:0]       pm25_q, pm10_q;
  logic [aqi_pkg::COL_RECIP_W-1:0] recip;
  logic [aqi_pkg::COL_PROD_W-1:0]  pa, pb;
  logic [aqi_pkg::COLOR_W-1:0]     qa, qb;
  aqi_pkg::result_t                res_d, res_q;

  // Stage 1: maximum of the enabled indices, category, ramp numerators.
  always_comb begin
    final_d = '0;
    if (use_pm25_i && (pm25_index_i > final_d)) begin
      final_d = pm25_index_i;
    end
    if (use_pm10_i && (pm10_index_i > final_d)) begin
      final_d = pm10_index_i;
    end

    if (final_d <= aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[1])) begin
      cat_d = aqi_pkg::CAT_GOOD;
    end else if (final_d <= aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[2])) begin
      cat_d = aqi_pkg::CAT_MODERATE;
    end else if (final_d <= aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[3])) begin
      cat_d = aqi_pkg::CAT_SENSITIVE;
    end else if (final_d <= aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[4])) begin
      cat_d = aqi_pkg::CAT_UNHEALTHY;
    end else if (final_d <= aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[5])) begin
      cat_d = aqi_pkg::CAT_VERY_UNHEALTHY;
    end else begin
      cat_d = aqi_pkg::CAT_HAZARDOUS;
    end

    rng_d = aqi_pkg::COL_LOW;
    xa    = '0;
    xb    = '0;
    if (final_d <= aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[1])) begin
      rng_d = aqi_pkg::COL_LOW;
    end else if (final_d <= aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[2])) begin
      rng_d = aqi_pkg::COL_MID;
      xa    = final_d - aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[1]);
      xb    = aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[2]) - final_d;
    end else if (final_d <= aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[5])) begin
      rng_d = aqi_pkg::COL_HIGH;
      xa    = final_d - aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[2]);
      xb    = aqi_pkg::IDX_W'(aqi_pkg::IDX_BP[5]) - final_d;
    end else begin
      rng_d = aqi_pkg::COL_TOP;
    end
    na_d = aqi_pkg::COL_NUM_W'(xa) * aqi_pkg::COL_NUM_W'(aqi_pkg::FULL_SCALE);
    nb_d = aqi_pkg::COL_NUM_W'(xb) * aqi_pkg::COL_NUM_W'(aqi_pkg::FULL_SCALE);
  end

  // Stage 2: divide the numerators by the ramp span and pick the colour.
  always_comb begin
    recip = (rng_q == aqi_pkg::COL_MID) ? aqi_pkg::COL_MID_RECIP : aqi_pkg::COL_HIGH_RECIP;
    pa    = aqi_pkg::COL_PROD_W'(na_q) * aqi_pkg::COL_PROD_W'(recip);
    pb    = aqi_pkg::COL_PROD_W'(nb_q) * aqi_pkg::COL_PROD_W'(recip);
    qa    = pa[aqi_pkg::COL_SHIFT +: aqi_pkg::COLOR_W];
    qb    = pb[aqi_pkg::COL_SHIFT +: aqi_pkg::COLOR_W];

    res_d.pm25_index  = pm25_q;
    res_d.pm10_index  = pm10_q;
    res_d.final_index = final_q;
    res_d.category    = cat_q;
    case (rng_q)
      aqi_pkg::COL_LOW: begin
        res_d.red   = '0;
        res_d.green = '0;
        res_d.blue  = aqi_pkg::COLOR_W'(aqi_pkg::FULL_SCALE);
      end
      aqi_pkg::COL_MID: begin
        res_d.red   = '0;
        res_d.green = qa;
        res_d.blue  = qb;
      end
      aqi_pkg::COL_HIGH: begin
        res_d.red   = qa;
        res_d.green = qb;
        res_d.blue  = '0;
      end
      default: begin
        res_d.red   = aqi_pkg::COLOR_W'(aqi_pkg::FULL_SCALE);
        res_d.green = '0;
        res_d.blue  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.merge_s1) begin
      pm25_q  <= pm25_index_i;
      pm10_q  <= pm10_index_i;
      final_q <= final_d;
      cat_q   <= cat_d;
      rng_q   <= rng_d;
      na_q    <= na_d;
      nb_q    <= nb_d;
    end
    if (en_i.merge_s2) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule
